@@ hdl/bsls_pkg.sv @@
package bsls_pkg;

  localparam int CAPACITY = 32;
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed item field widths
  localparam int CMD_W    = 4;
  localparam int IDX_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 6;
  localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam int IN_BITS  = IDX_W + VAL_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = VAL_W + ECNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUSER_W  = STAT_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FIRST    = 4'd0,
    CMD_ADD_LAST     = 4'd1,
    CMD_ADD_AT       = 4'd2,
    CMD_REMOVE_FIRST = 4'd3,
    CMD_REMOVE_LAST  = 4'd4,
    CMD_GET_FIRST    = 4'd5,
    CMD_GET_LAST     = 4'd6,
    CMD_GET_AT       = 4'd7,
    CMD_GET_FROM_END = 4'd8,
    CMD_MID          = 4'd9,
    CMD_REVERSE      = 4'd10,
    CMD_DUMP         = 4'd11
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Map a logical position onto a physical slot of the circular store.
  // The front sits at hd; rev set means the order runs downwards.
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] hd,
                                            input logic              rev,
                                            input logic [CNT_W-1:0]  lidx);
    logic [CNT_W:0] h;
    logic [CNT_W:0] l;
    logic [CNT_W:0] s;
    logic [CNT_W:0] cap;
    h   = (CNT_W+1)'(hd);
    l   = (CNT_W+1)'(lidx);
    cap = (CNT_W+1)'(CAPACITY);
    if (!rev) begin
      s = h + l;
      if (s >= cap) s = s - cap;
    end else begin
      if (h >= l) s = h - l;
      else        s = h + cap - l;
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

@@ hdl/bsls_ram.sv @@
module bsls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/bounded_sequence_list_store_unit.sv @@
// Removes, reverse and refused commands answer from the response state once the item is taken.
// Insert at p: entries from the back down to p move up by a RAM read and write each; front and
// back inserts need no shift. Reads wait on one RAM read; a dump does one RAM read per entry.
// Throughput: one item at a time; s_tready is high only while the sequencer idles.
// Reset (rst, synchronous, active high) empties the store and drops m_tvalid;
// the entry RAM is left as it is and needs no clearing pass.
module bounded_sequence_list_store_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [bsls_pkg::IN_W-1:0]   s_tdata,   // index[5:0], value[37:6], zero fill
  input  logic [bsls_pkg::CMD_W-1:0]  s_tuser,   // cmd[3:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bsls_pkg::OUT_W-1:0]  m_tdata,   // read_value[31:0], entry_count[37:32], zero fill
  output logic [bsls_pkg::OUSER_W-1:0] m_tuser,  // status[1:0], has_value[2]
  output logic                        m_tlast    // is_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_RESP,
    S_RD_WAIT,
    S_EMIT
  } state_t;

  state_t                        state;
  logic [bsls_pkg::CNT_W-1:0]    count;
  logic [bsls_pkg::PTR_W-1:0]    head;      // physical slot of the front entry
  logic                          dir;       // order runs downwards from head
  logic [bsls_pkg::CNT_W-1:0]    cur;       // logical position being worked on
  logic [bsls_pkg::CNT_W-1:0]    stop_idx;  // last logical position to read out
  logic [bsls_pkg::CNT_W-1:0]    pos;       // insert position
  logic [bsls_pkg::VAL_W-1:0]    val;       // value to insert
  bsls_pkg::status_t             resp_status;

  // Unpack the incoming item
  logic [bsls_pkg::CMD_W-1:0]    in_cmd;
  logic [bsls_pkg::IDX_W-1:0]    in_idx;
  logic [bsls_pkg::VAL_W-1:0]    in_val;
  logic [bsls_pkg::CMP_W-1:0]    idx_c;
  logic [bsls_pkg::CMP_W-1:0]    cnt_c;
  logic [bsls_pkg::CMP_W-1:0]    ins_pos;
  logic [bsls_pkg::CNT_W-1:0]    last_idx;
  logic [bsls_pkg::CNT_W-1:0]    from_end_idx;
  logic                          full;
  logic                          out_free;
  logic                          out_load;  // output register takes a new item this cycle

  assign in_cmd   = s_tuser;
  assign in_idx   = s_tdata[bsls_pkg::IDX_W-1:0];
  assign in_val   = s_tdata[bsls_pkg::IDX_W +: bsls_pkg::VAL_W];
  assign idx_c    = bsls_pkg::CMP_W'(in_idx);
  assign cnt_c    = bsls_pkg::CMP_W'(count);
  assign last_idx = count - bsls_pkg::CNT_W'(1);
  assign from_end_idx = last_idx - bsls_pkg::CNT_W'(in_idx);
  assign full     = (cnt_c >= bsls_pkg::CMP_W'(bsls_pkg::CAPACITY));
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (state == S_RESP || state == S_EMIT);
  assign s_tready = (state == S_IDLE);

  always_comb begin
    case (in_cmd)
      bsls_pkg::CMD_ADD_FIRST: ins_pos = '0;
      bsls_pkg::CMD_ADD_LAST:  ins_pos = cnt_c;
      default:                 ins_pos = idx_c;
    endcase
  end

  // Entry RAM and its address unit
  logic                          ram_we;
  logic [bsls_pkg::PTR_W-1:0]    ram_waddr;
  logic [bsls_pkg::VAL_W-1:0]    ram_wdata;
  logic [bsls_pkg::PTR_W-1:0]    ram_raddr;
  logic [bsls_pkg::VAL_W-1:0]    ram_rdata;
  logic [bsls_pkg::PTR_W-1:0]    front_slot;  // slot just ahead of the front

  assign front_slot = bsls_pkg::phys(head, !dir, bsls_pkg::CNT_W'(1));

  always_comb begin
    // Shifting reads the entry one below the one being written
    if (state == S_SHIFT_RD || state == S_SHIFT_WR)
      ram_raddr = bsls_pkg::phys(head, dir, cur - bsls_pkg::CNT_W'(1));
    else
      ram_raddr = bsls_pkg::phys(head, dir, cur);
    ram_we    = 1'b0;
    ram_waddr = bsls_pkg::phys(head, dir, cur);
    ram_wdata = ram_rdata;
    if (state == S_SHIFT_WR) begin
      ram_we = 1'b1;
    end else if (state == S_INS_WR) begin
      ram_we    = 1'b1;
      ram_wdata = val;
      ram_waddr = (pos == '0) ? front_slot : bsls_pkg::phys(head, dir, pos);
    end
  end

  bsls_ram #(
    .WIDTH(bsls_pkg::VAL_W),
    .DEPTH(bsls_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      head     <= '0;
      dir      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop the held item once taken, unless a new one is loaded below
      if (m_tready && !out_load) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            case (in_cmd)
              bsls_pkg::CMD_ADD_FIRST, bsls_pkg::CMD_ADD_LAST, bsls_pkg::CMD_ADD_AT: begin
                if (ins_pos > cnt_c) begin
                  resp_status <= bsls_pkg::ST_BADPOS;
                  state       <= S_RESP;
                end else if (full) begin
                  resp_status <= bsls_pkg::ST_FULL;
                  state       <= S_RESP;
                end else begin
                  pos <= bsls_pkg::CNT_W'(ins_pos);
                  val <= in_val;
                  cur <= count;
                  // Front and back inserts need no shift
                  if (ins_pos == cnt_c || ins_pos == '0) state <= S_INS_WR;
                  else                                   state <= S_SHIFT_RD;
                end
              end
              bsls_pkg::CMD_REMOVE_FIRST: begin
                state <= S_RESP;
                if (count == '0) begin
                  resp_status <= bsls_pkg::ST_EMPTY;
                end else begin
                  resp_status <= bsls_pkg::ST_OK;
                  head        <= bsls_pkg::phys(head, dir, bsls_pkg::CNT_W'(1));
                  count       <= last_idx;
                end
              end
              bsls_pkg::CMD_REMOVE_LAST: begin
                state <= S_RESP;
                if (count == '0) begin
                  resp_status <= bsls_pkg::ST_EMPTY;
                end else begin
                  resp_status <= bsls_pkg::ST_OK;
                  count       <= last_idx;
                end
              end
              bsls_pkg::CMD_GET_FIRST, bsls_pkg::CMD_GET_LAST, bsls_pkg::CMD_MID: begin
                if (count == '0) begin
                  resp_status <= bsls_pkg::ST_EMPTY;
                  state       <= S_RESP;
                end else begin
                  state <= S_RD_WAIT;
                  if (in_cmd == bsls_pkg::CMD_GET_FIRST) begin
                    cur <= '0;  stop_idx <= '0;
                  end else if (in_cmd == bsls_pkg::CMD_GET_LAST) begin
                    cur <= last_idx;  stop_idx <= last_idx;
                  end else begin
                    cur <= last_idx >> 1;  stop_idx <= last_idx >> 1;
                  end
                end
              end
              bsls_pkg::CMD_GET_AT, bsls_pkg::CMD_GET_FROM_END: begin
                if (idx_c >= cnt_c) begin
                  resp_status <= bsls_pkg::ST_BADPOS;
                  state       <= S_RESP;
                end else begin
                  state <= S_RD_WAIT;
                  if (in_cmd == bsls_pkg::CMD_GET_AT) begin
                    cur      <= bsls_pkg::CNT_W'(in_idx);
                    stop_idx <= bsls_pkg::CNT_W'(in_idx);
                  end else begin
                    cur      <= from_end_idx;
                    stop_idx <= from_end_idx;
                  end
                end
              end
              bsls_pkg::CMD_REVERSE: begin
                // Reverse in place: the back becomes the front, direction flips
                resp_status <= bsls_pkg::ST_OK;
                state       <= S_RESP;
                if (count > bsls_pkg::CNT_W'(1)) begin
                  head <= bsls_pkg::phys(head, dir, last_idx);
                  dir  <= !dir;
                end
              end
              bsls_pkg::CMD_DUMP: begin
                if (count == '0) begin
                  resp_status <= bsls_pkg::ST_EMPTY;
                  state       <= S_RESP;
                end else begin
                  cur      <= '0;
                  stop_idx <= last_idx;
                  state    <= S_RD_WAIT;
                end
              end
              default: begin
                // Unused codes answer ok
                resp_status <= bsls_pkg::ST_OK;
                state       <= S_RESP;
              end
            endcase
          end
        end

        S_SHIFT_RD: state <= S_SHIFT_WR;

        S_SHIFT_WR: begin
          // Entry cur-1 moves up to cur
          cur <= cur - bsls_pkg::CNT_W'(1);
          if (cur - bsls_pkg::CNT_W'(1) == pos) state <= S_INS_WR;
          else                                  state <= S_SHIFT_RD;
        end

        S_INS_WR: begin
          if (pos == '0) head <= front_slot;
          count       <= count + bsls_pkg::CNT_W'(1);
          resp_status <= bsls_pkg::ST_OK;
          state       <= S_RESP;
        end

        S_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {1'b0, resp_status};
            m_tdata  <= bsls_pkg::OUT_W'({bsls_pkg::ECNT_W'(count), bsls_pkg::VAL_W'(0)});
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end

        S_RD_WAIT: state <= S_EMIT;

        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {1'b1, bsls_pkg::ST_OK};
            m_tdata  <= bsls_pkg::OUT_W'({bsls_pkg::ECNT_W'(count), ram_rdata});
            m_tlast  <= (cur == stop_idx);
            if (cur == stop_idx) begin
              state <= S_IDLE;
            end else begin
              cur   <= cur + bsls_pkg::CNT_W'(1);
              state <= S_RD_WAIT;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/bsls_checker.sv @@
module bsls_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [bsls_pkg::IN_W-1:0]    s_tdata,
  input logic [bsls_pkg::CMD_W-1:0]   s_tuser,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [bsls_pkg::OUT_W-1:0]   m_tdata,
  input logic [bsls_pkg::OUSER_W-1:0] m_tuser,
  input logic                         m_tlast
);

  logic [bsls_pkg::STAT_W-1:0] st;
  logic                        has;
  logic [bsls_pkg::ECNT_W-1:0] ecnt;

  assign st   = m_tuser[bsls_pkg::STAT_W-1:0];
  assign has  = m_tuser[bsls_pkg::STAT_W];
  assign ecnt = m_tdata[bsls_pkg::VAL_W +: bsls_pkg::ECNT_W];

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // No new item while a run is still being delivered
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("item taken in the middle of a run");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == bsls_pkg::ST_EMPTY |-> ecnt == '0)
    else $error("empty status with entries present");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == bsls_pkg::ST_FULL |-> ecnt == bsls_pkg::ECNT_W'(bsls_pkg::CAPACITY))
    else $error("full status below capacity");

  a_value_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && has |-> st == bsls_pkg::ST_OK)
    else $error("value delivered with a fault status");

endmodule

bind bounded_sequence_list_store_unit bsls_checker u_bsls_checker (.*);

@@ tb/bounded_sequence_list_store_unit_tb.sv @@
module bounded_sequence_list_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsls_pkg::*;

  // Spare command codes that the block must answer with a plain ok.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd12;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  localparam int RANDOM_ITEMS = 150;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;

  // One result item as the block presents it.
  typedef struct packed {
    status_t           status;
    logic              has_value;
    logic [VAL_W-1:0]  read_value;
    logic [ECNT_W-1:0] entry_count;
    logic              is_last;
  } list_result_t;

  // Shadow copy of the list plus the queue of results still owed by the block.
  class list_scoreboard;
    logic [VAL_W-1:0] store [CAPACITY];
    int unsigned      fill = 0;
    list_result_t     owed [$];
    int               errors = 0;

    function void owe(status_t st, logic has, logic [VAL_W-1:0] v, logic last);
      list_result_t r;
      r.status      = st;
      r.has_value   = has;
      r.read_value  = has ? v : '0;
      r.entry_count = ECNT_W'(fill);
      r.is_last     = last;
      owed.push_back(r);
    endfunction

    function status_t place(int unsigned pos, logic [VAL_W-1:0] v);
      if (pos > fill) return ST_BADPOS;
      if (fill >= CAPACITY) return ST_FULL;
      for (int unsigned i = fill; i > pos; i--) store[i] = store[i-1];
      store[pos] = v;
      fill++;
      return ST_OK;
    endfunction

    // Apply one accepted item to the shadow list and queue what it should produce.
    function void note_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                            logic [VAL_W-1:0] v);
      int unsigned      pos;
      int unsigned      lo;
      int unsigned      hi;
      logic [VAL_W-1:0] t;
      case (cmd)
        CMD_ADD_FIRST: owe(place(0, v), 1'b0, '0, 1'b1);
        CMD_ADD_LAST:  owe(place(fill, v), 1'b0, '0, 1'b1);
        CMD_ADD_AT:    owe(place(idx, v), 1'b0, '0, 1'b1);
        CMD_REMOVE_FIRST, CMD_REMOVE_LAST: begin
          if (fill == 0) begin
            owe(ST_EMPTY, 1'b0, '0, 1'b1);
          end else begin
            if (cmd == CMD_REMOVE_FIRST)
              for (int unsigned i = 0; i + 1 < fill; i++) store[i] = store[i+1];
            fill--;
            owe(ST_OK, 1'b0, '0, 1'b1);
          end
        end
        CMD_GET_FIRST, CMD_GET_LAST, CMD_MID: begin
          if (fill == 0) begin
            owe(ST_EMPTY, 1'b0, '0, 1'b1);
          end else begin
            pos = (cmd == CMD_GET_FIRST) ? 0 :
                  (cmd == CMD_GET_LAST) ? fill - 1 : (fill - 1) / 2;
            owe(ST_OK, 1'b1, store[pos], 1'b1);
          end
        end
        CMD_GET_AT, CMD_GET_FROM_END: begin
          if (idx >= fill) begin
            owe(ST_BADPOS, 1'b0, '0, 1'b1);
          end else begin
            pos = (cmd == CMD_GET_AT) ? idx : fill - 1 - idx;
            owe(ST_OK, 1'b1, store[pos], 1'b1);
          end
        end
        CMD_REVERSE: begin
          if (fill > 1) begin
            lo = 0;
            hi = fill - 1;
            while (lo < hi) begin
              t         = store[lo];
              store[lo] = store[hi];
              store[hi] = t;
              lo++;
              hi--;
            end
          end
          owe(ST_OK, 1'b0, '0, 1'b1);
        end
        CMD_DUMP: begin
          if (fill == 0) owe(ST_EMPTY, 1'b0, '0, 1'b1);
          else
            for (int unsigned i = 0; i < fill; i++)
              owe(ST_OK, 1'b1, store[i], i + 1 == fill);
        end
        default: owe(ST_OK, 1'b0, '0, 1'b1);
      endcase
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (owed.size() == 0) begin
        $error("result item with nothing owed: status %0d value %0h count %0d",
               got.status, got.read_value, got.entry_count);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.has_value !== want.has_value) begin
        $error("has_value: expected %0d, got %0d", want.has_value, got.has_value);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0h, got %0h", want.read_value, got.read_value);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.is_last !== want.is_last) begin
        $error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata  = '0;
  logic [CMD_W-1:0]     s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic [OUSER_W-1:0]   m_tuser;
  logic                 m_tlast;

  list_scoreboard sb = new;
  int             burst_left = 0;
  int unsigned    cycles     = 0;
  int unsigned    rx_tick    = 0;
  int unsigned    rx_mode    = 0;

  bounded_sequence_list_store_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bounded_sequence_list_store_unit_tb: FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: rx_tick picks a new one of four stall patterns at random
  // so that stalls land on single results as well as inside dump runs.
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1);
      2:       m_tready <= (rx_tick % 4) != 0;
      default: m_tready <= $urandom_range(0, 5) == 0;
    endcase
  end

  // Compare every result item taken from the block against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result({status_t'(m_tuser[STAT_W-1:0]), m_tuser[STAT_W],
                       m_tdata[VAL_W-1:0], m_tdata[VAL_W +: ECNT_W], m_tlast});
  end

  // Offer one item and hold it until the block takes it. Items go out in bursts
  // of random length; between bursts tvalid may drop for a random gap.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                           logic [VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= IN_W'({v, idx});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(cmd, idx, v);
    burst_left--;
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] v;
    int unsigned      roll;
    bit               grow;
    int               full_tries;

    // Hold reset, then release it once.
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: read, remove, reverse, dump, spare and past-the-end add commands on an empty store first.
    send_item(CMD_GET_FIRST,    6'd0,  32'h0);
    send_item(CMD_GET_LAST,     6'd0,  32'h0);
    send_item(CMD_MID,          6'd0,  32'h0);
    send_item(CMD_REMOVE_FIRST, 6'd0,  32'h0);
    send_item(CMD_REMOVE_LAST,  6'd0,  32'h0);
    send_item(CMD_DUMP,         6'd0,  32'h0);
    send_item(CMD_GET_AT,       6'd0,  32'h0);
    send_item(CMD_GET_FROM_END, 6'd0,  32'h0);
    send_item(CMD_REVERSE,      6'd0,  32'h0);
    send_item(CMD_SPARE_LO,     6'd63, 32'hFFFF_FFFF);
    send_item(CMD_SPARE_HI,     6'd0,  32'h0);
    send_item(CMD_ADD_AT,       6'd1,  32'h1234_5678);   // past the end
    // Build a short list with extreme values, reverse it, then read it by dump, mid, index and from the end.
    send_item(CMD_ADD_FIRST,    6'd0,  32'h8000_0000);
    send_item(CMD_ADD_LAST,     6'd0,  32'h7FFF_FFFF);
    send_item(CMD_ADD_AT,       6'd1,  32'hFFFF_FFFF);
    send_item(CMD_ADD_AT,       6'd4,  32'h0);           // one beyond count
    send_item(CMD_REVERSE,      6'd0,  32'h0);
    send_item(CMD_DUMP,         6'd0,  32'h0);
    send_item(CMD_MID,          6'd0,  32'h0);
    send_item(CMD_GET_AT,       6'd2,  32'h0);
    send_item(CMD_GET_FROM_END, 6'd2,  32'h0);
    send_item(CMD_GET_FROM_END, 6'd3,  32'h0);
    send_item(CMD_GET_AT,       6'd63, 32'h0);
    send_item(CMD_REMOVE_FIRST, 6'd0,  32'h0);
    send_item(CMD_REMOVE_LAST,  6'd0,  32'h0);
    send_item(CMD_REVERSE,      6'd0,  32'h0);           // single entry

    // Random: grow the list until it is full and inserts bounce a few times,
    // then drain it; regrow once it runs dry.
    grow       = 1'b1;
    full_tries = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0;
          default: v = 32'hFFFF_FFFF;
        endcase
      end else begin
        v = $urandom;
      end
      idx = 6'($urandom_range(0, 63));
      if (roll < 2) begin
        cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end else if (roll < (grow ? 70 : 17)) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_ADD_FIRST;
          1:       cmd = CMD_ADD_LAST;
          default: cmd = CMD_ADD_AT;
        endcase
        if (cmd == CMD_ADD_AT)
          idx = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(sb.fill + 1, 63))
                                            : 6'($urandom_range(0, sb.fill));
      end else if (roll < (grow ? 80 : 65)) begin
        cmd = $urandom_range(0, 1) ? CMD_REMOVE_FIRST : CMD_REMOVE_LAST;
      end else if (roll < 95) begin
        case ($urandom_range(0, 5))
          0:       cmd = CMD_GET_FIRST;
          1:       cmd = CMD_GET_LAST;
          2:       cmd = CMD_GET_AT;
          3:       cmd = CMD_GET_FROM_END;
          4:       cmd = CMD_MID;
          default: cmd = CMD_REVERSE;
        endcase
        if (cmd == CMD_GET_AT || cmd == CMD_GET_FROM_END)
          idx = (sb.fill == 0 || $urandom_range(0, 6) == 0)
                ? 6'($urandom_range(sb.fill, 63)) : 6'($urandom_range(0, sb.fill - 1));
      end else begin
        cmd = CMD_DUMP;
      end
      send_item(cmd, idx, v);
      if (sb.fill == CAPACITY) begin
        full_tries++;
        if (full_tries > 3) grow = 1'b0;
      end else if (sb.fill == 0) begin
        grow       = 1'b1;
        full_tries = 0;
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every owed result, then a margin to catch stray extras.
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("bounded_sequence_list_store_unit_tb: PASS");
    else
      $display("bounded_sequence_list_store_unit_tb: FAIL");
    $finish;
  end

endmodule
